// ----- sv/wscm_pkg.sv -----
`timescale 1ns / 1ps

package wscm_pkg;

	// Configuration port geometry.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Register indexes on the configuration port; register i sits at byte address 4*i.
	localparam logic [2:0] REG_TIMER_PERIOD  = 3'd0;
	localparam logic [2:0] REG_COUNT_RATE    = 3'd1;
	localparam logic [2:0] REG_CIRCUMFERENCE = 3'd2;
	localparam logic [2:0] REG_PULSES        = 3'd3;
	localparam logic [2:0] REG_TIMEOUT       = 3'd4;

	// Field widths of the configuration registers.
	localparam int TP_W    = 17;
	localparam int RATE_W  = 27;
	localparam int CIRC_W  = 14;
	localparam int PULSE_W = 7;
	localparam int TMO_W   = 16;

	// Serial multiplier: 32-bit multiplicand, 21-bit multiplier, 53-bit product.
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 21;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Serial divider: 55-bit dividend, 53-bit divisor, 16-bit saturated quotient.
	localparam int NUM_W = 55;
	localparam int DEN_W = 53;
	localparam int QUO_W = 16;

	typedef struct packed {
		logic [TP_W-1:0]    timer_period_ticks;
		logic [RATE_W-1:0]  count_rate_hz;
		logic [CIRC_W-1:0]  circumference_mm;
		logic [PULSE_W-1:0] pulses_per_turn;
		logic [TMO_W-1:0]   timeout_overflows;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TICK_CHK,
		S_P_MUL,
		S_P_WAIT,
		S_P_STORE,
		S_NUM_MUL,
		S_NUM_WAIT,
		S_NUM_STORE,
		S_WHEEL,
		S_DEN_WAIT,
		S_DIV_WAIT,
		S_EMIT
	} state_t;

endpackage

// ----- sv/wscm_regs.sv -----
`timescale 1ns / 1ps

module wscm_regs import wscm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timer_period_ticks <= TP_W'(65536);
			cfg_q.count_rate_hz      <= RATE_W'(1000000);
			cfg_q.circumference_mm   <= CIRC_W'(1600);
			cfg_q.pulses_per_turn    <= PULSE_W'(4);
			cfg_q.timeout_overflows  <= TMO_W'(10);
		end else if (wr_en) begin
			case (reg_idx)
				REG_TIMER_PERIOD:  cfg_q.timer_period_ticks <= pwdata[TP_W-1:0];
				REG_COUNT_RATE:    cfg_q.count_rate_hz      <= pwdata[RATE_W-1:0];
				REG_CIRCUMFERENCE: cfg_q.circumference_mm   <= pwdata[CIRC_W-1:0];
				REG_PULSES:        cfg_q.pulses_per_turn    <= pwdata[PULSE_W-1:0];
				REG_TIMEOUT:       cfg_q.timeout_overflows  <= pwdata[TMO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TIMER_PERIOD:  prdata = DATA_W'(cfg_q.timer_period_ticks);
			REG_COUNT_RATE:    prdata = DATA_W'(cfg_q.count_rate_hz);
			REG_CIRCUMFERENCE: prdata = DATA_W'(cfg_q.circumference_mm);
			REG_PULSES:        prdata = DATA_W'(cfg_q.pulses_per_turn);
			REG_TIMEOUT:       prdata = DATA_W'(cfg_q.timeout_overflows);
			default:           prdata = '0;
		endcase
	end

endmodule

// ----- sv/wscm_serial_mult.sv -----
`timescale 1ns / 1ps

// Shift-add multiplier: one multiplier bit per cycle, stops once the
// remaining multiplier bits are all zero.
module wscm_serial_mult import wscm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic               done,
	output logic [MUL_P_W-1:0] prod
);

	logic               busy_q;
	logic               done_q;
	logic [MUL_P_W-1:0] a_sh_q;
	logic [MUL_B_W-1:0] b_q;
	logic [MUL_P_W-1:0] acc_q;

	assign done = done_q;
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (b_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (b_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_sh_q <= MUL_P_W'(a);
			b_q    <= b;
			acc_q  <= '0;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_sh_q;
			end
			a_sh_q <= {a_sh_q[MUL_P_W-2:0], 1'b0};
			b_q    <= {1'b0, b_q[MUL_B_W-1:1]};
		end
	end

endmodule

// ----- sv/wscm_serial_div.sv -----
`timescale 1ns / 1ps

// Restoring divider: one quotient bit per cycle, seventeen bits in all. The top
// quotient bit only flags that the result does not fit in sixteen bits.
module wscm_serial_div import wscm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	localparam int DSH_W = DEN_W + QUO_W;
	localparam int CNT_W = $clog2(QUO_W + 2);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [QUO_W:0]   q_q;
	logic             ge;

	assign ge   = DSH_W'(rem_q) >= dsh_q;
	assign done = done_q;
	assign quo  = q_q[QUO_W] ? {QUO_W{1'b1}} : q_q[QUO_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W + 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {den, {QUO_W{1'b0}}};
			q_q   <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[NUM_W-1:0];
			end
			q_q   <= {q_q[QUO_W-1:0], ge};
			dsh_q <= {1'b0, dsh_q[DSH_W-1:1]};
		end
	end

endmodule

// ----- sv/wheel_speed_capture_meter.sv -----
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------
// in      | in_valid / in_ready  | mode, channel, capture_count
// out     | out_valid / out_ready| speed_kmh, timed_out
// config  | APB psel/penable     | paddr, pwdata, prdata (pready high)
//
// The block works on one item at a time. A tick runs a watchdog check and, when
// it trips the watchdog, emits a timeout result. A capture on a front channel
// first measures its wheel period; the shift-add multiplier (one multiplier bit a
// cycle) and the restoring divider (seventeen quotient bits) then give the speeds.
// Reset clears all wheel state, loads the register defaults and leaves the
// result register empty. A result waiting in the output register holds the
// next one back only at its final step.
module wheel_speed_capture_meter import wscm_pkg::*; #(
	parameter int COUNTER_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [1:0]        channel,
	input  logic [15:0]       capture_count,

	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        speed_kmh,
	output logic              timed_out
);

	// Captures are compared only on the low COUNTER_BITS bits of the timer.
	localparam logic [15:0] CNT_MASK = (COUNTER_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << COUNTER_BITS) - 32'd1);

	cfg_t   cfg;
	state_t state_q, state_d;

	// Wheel state.
	logic [31:0] overflow_total_q;
	logic [31:0] last_snap_q;
	logic [15:0] prev_cap_q [2];
	logic [31:0] wheel_snap_q [2];
	logic [31:0] period_q [2];
	logic [15:0] speed_q [2];

	// Per-item working registers.
	logic             wheel_q;
	logic [15:0]      cap_q;
	logic             res_to_q;
	logic [NUM_W-1:0] num_q;

	// Result register.
	logic       out_valid_q;
	logic [7:0] out_speed_q;
	logic       out_to_q;

	// Shared arithmetic units.
	logic               mul_start;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic               mul_done;
	logic [MUL_P_W-1:0] mul_prod;
	logic               div_start;
	logic               div_done;
	logic [QUO_W-1:0]   div_quo;

	logic               accept;
	logic               out_free;
	logic               timeout_hit;
	logic               period_nz;
	logic [PULSE_W-1:0] pulses_eff;
	logic [MUL_B_W-1:0] den_scale;
	logic signed [50:0] p_s;
	logic [31:0]        p_sat;
	logic [44:0]        rate_circ_x9;
	logic [16:0]        speed_sum;

	wscm_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	wscm_serial_mult u_mult (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	wscm_serial_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_q),
		.den   (mul_prod[DEN_W-1:0]),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign pready    = 1'b1;
	assign out_valid = out_valid_q;
	assign speed_kmh = out_speed_q;
	assign timed_out = out_to_q;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// The watchdog compares the overflows seen since the last capture or timeout.
	assign timeout_hit = (overflow_total_q - last_snap_q) >= 32'(cfg.timeout_overflows);

	assign period_nz = period_q[wheel_q] != '0;

	// Divisor scale is 10000 times the pulse count, with zero pulses taken as one.
	assign pulses_eff = (cfg.pulses_per_turn == '0) ? PULSE_W'(1) : cfg.pulses_per_turn;
	assign den_scale  = MUL_B_W'(MUL_B_W'(pulses_eff) * MUL_B_W'(10000));

	// Period is overflow ticks plus the capture difference, which may go negative.
	assign p_s = $signed({2'b00, mul_prod[48:0]}) + $signed({35'd0, cap_q}) -
		$signed({35'd0, prev_cap_q[wheel_q] & CNT_MASK});

	always_comb begin
		if (p_s[50] || (p_s == '0)) begin
			p_sat = '0;
		end else if (p_s[49:32] != '0) begin
			p_sat = '1;
		end else begin
			p_sat = p_s[31:0];
		end
	end

	// Numerator is circumference times rate times 9216, the product of 36, 256
	// and the 1/10000 that sits in the divisor; 9216 is nine shifted by ten.
	assign rate_circ_x9 = {4'd0, mul_prod[40:0]} + {1'b0, mul_prod[40:0], 3'd0};

	assign speed_sum = {1'b0, speed_q[0]} + {1'b0, speed_q[1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!mode) begin
						state_d = S_TICK_CHK;
					end else if (channel[1]) begin
						state_d = S_NUM_MUL;
					end else begin
						state_d = S_P_MUL;
					end
				end
			end
			S_TICK_CHK:  state_d = timeout_hit ? S_EMIT : S_IDLE;
			S_P_MUL:     state_d = S_P_WAIT;
			S_P_WAIT:    state_d = mul_done ? S_P_STORE : S_P_WAIT;
			S_P_STORE:   state_d = S_NUM_MUL;
			S_NUM_MUL:   state_d = S_NUM_WAIT;
			S_NUM_WAIT:  state_d = mul_done ? S_NUM_STORE : S_NUM_WAIT;
			S_NUM_STORE: state_d = S_WHEEL;
			S_WHEEL: begin
				if (period_nz) begin
					state_d = S_DEN_WAIT;
				end else begin
					state_d = wheel_q ? S_EMIT : S_WHEEL;
				end
			end
			S_DEN_WAIT:  state_d = mul_done ? S_DIV_WAIT : S_DEN_WAIT;
			S_DIV_WAIT: begin
				if (div_done) begin
					state_d = wheel_q ? S_EMIT : S_WHEEL;
				end
			end
			S_EMIT:      state_d = out_free ? S_IDLE : S_EMIT;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_P_MUL: begin
				mul_start = 1'b1;
				mul_a     = overflow_total_q - wheel_snap_q[wheel_q];
				mul_b     = MUL_B_W'(cfg.timer_period_ticks);
			end
			S_NUM_MUL: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(cfg.count_rate_hz);
				mul_b     = MUL_B_W'(cfg.circumference_mm);
			end
			S_WHEEL: begin
				mul_start = period_nz;
				mul_a     = period_q[wheel_q];
				mul_b     = den_scale;
			end
			S_DEN_WAIT: div_start = mul_done;
			default: begin
			end
		endcase
	end

	// Wheel state and per-item registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_total_q <= '0;
			last_snap_q      <= '0;
			prev_cap_q[0]    <= '0;
			prev_cap_q[1]    <= '0;
			wheel_snap_q[0]  <= '0;
			wheel_snap_q[1]  <= '0;
			period_q[0]      <= '0;
			period_q[1]      <= '0;
			speed_q[0]       <= '0;
			speed_q[1]       <= '0;
			wheel_q          <= 1'b0;
			res_to_q         <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!mode) begin
							overflow_total_q <= overflow_total_q + 32'd1;
						end else begin
							last_snap_q <= overflow_total_q;
							wheel_q     <= channel[0];
							res_to_q    <= 1'b0;
						end
					end
				end
				S_TICK_CHK: begin
					if (timeout_hit) begin
						speed_q[0]  <= '0;
						speed_q[1]  <= '0;
						last_snap_q <= overflow_total_q;
						res_to_q    <= 1'b1;
					end
				end
				S_P_STORE: begin
					period_q[wheel_q]     <= p_sat;
					prev_cap_q[wheel_q]   <= cap_q;
					wheel_snap_q[wheel_q] <= overflow_total_q;
				end
				S_NUM_STORE: wheel_q <= 1'b0;
				S_WHEEL: begin
					if (!period_nz) begin
						wheel_q <= 1'b1;
					end
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						speed_q[wheel_q] <= div_quo;
						wheel_q          <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers of the working set need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cap_q <= capture_count & CNT_MASK;
		end
		if (state_q == S_NUM_STORE) begin
			num_q <= {rate_circ_x9, 10'd0};
		end
	end

	// Result register: a finished item waits here while the next one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// After a timeout both speeds are zero, so the average is zero as well.
	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && out_free) begin
			out_speed_q <= speed_sum[16:9];
			out_to_q    <= res_to_q;
		end
	end

endmodule
